// ===== sv/sfa_pkg.sv =====
// package: shared types, constants and codes of the segment fit allocator
package sfa_pkg;
    localparam int unsigned DefMaxEntries = 64;
    localparam int unsigned DefAddrBits   = 16;

    localparam logic [1:0] PolicyFirst = 2'd0;
    localparam logic [1:0] PolicyBest  = 2'd1;
    localparam logic [1:0] PolicyWorst = 2'd2;

    localparam logic OpCreate  = 1'b0;
    localparam logic OpRelease = 1'b1;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatCompact = 2'd1;
    localparam logic [1:0] StatNoMem   = 2'd2;
    localparam logic [1:0] StatFull    = 2'd3;

    localparam logic [15:0] MemSizeReset = 16'd4096;

    localparam int unsigned RegPolicy  = 0;
    localparam int unsigned RegMemSize = 1;

    typedef struct packed {
        logic [1:0] status;
        logic [15:0] seg_base;
        logic [15:0] seg_limit;
        logic [15:0] free_total;
    } t_result;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  process_id;
        logic [3:0]  segment_id;
        logic [15:0] request_size;
    } t_request;
endpackage

// ===== sv/sfa_if.sv =====
// interfaces: request and result channels
interface sfa_req_if import sfa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_request data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfa_rsp_if import sfa_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/segment_fit_allocator.sv =====
// top level: segment fit allocator with apb configuration
//  channel | dir | beat
//  req     | in  | opcode, process_id, segment_id, request_size
//  rsp     | out | status, seg_base, seg_limit, free_total
//  apb     | in  | fit_policy at 0x0, memory_size at 0x4
// a request scans the table entries through the one memory read port, then
// shifts rows up and writes the remainder hole when a hole splits.
// reset and a memory_size write rebuild the table.
// one request at a time; a held result blocks the next request.
module segment_fit_allocator import sfa_pkg::*; #(
    parameter int unsigned MaxEntries = DefMaxEntries,
    parameter int unsigned AddrBits   = DefAddrBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfa_req_if.sink     req,
    sfa_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned IdxBits = $clog2(MaxEntries);
    localparam int unsigned RowBits = 2 * AddrBits + 13;

    logic [1:0]         r_policy;
    logic [15:0]        r_msize;
    logic               wr, init, rd_en, wr_en, busy;
    logic [IdxBits-1:0] rd_idx, wr_idx;
    logic [RowBits-1:0] rd_row, wr_row;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign init   = wr && paddr[2] == 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_msize} : {30'd0, r_policy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= PolicyFirst;
            r_msize  <= MemSizeReset;
        end else if (wr) begin
            if (paddr[2] == 1'b0) begin
                r_policy <= pwdata[1:0];
            end else begin
                r_msize <= pwdata[15:0];
            end
        end
    end

    sfa_ctrl #(.MaxEntries(MaxEntries), .AddrBits(AddrBits)) u_ctrl (
        .i_clk, .i_rst_n, .i_policy(r_policy), .i_init(init),
        .i_init_size(pwdata[15:0]), .req, .rsp,
        .o_rd_en(rd_en), .o_rd_idx(rd_idx), .i_rd_row(rd_row),
        .o_wr_en(wr_en), .o_wr_idx(wr_idx), .o_wr_row(wr_row), .o_busy(busy)
    );

    sfa_table #(.MaxEntries(MaxEntries), .AddrBits(AddrBits)) u_table (
        .i_clk, .i_rd_en(rd_en), .i_rd_idx(rd_idx), .o_rd_row(rd_row),
        .i_wr_en(wr_en), .i_wr_idx(wr_idx), .i_wr_row(wr_row)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !req.ready) else $error("request taken while busy");
    a_ok_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.data.status != StatOk) |-> rsp.data.seg_base == 16'd0)
        else $error("failed request with nonzero base");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
endmodule

// ===== sv/sfa_table.sv =====
// table memory: one entry per row, one read and one write port
module sfa_table import sfa_pkg::*; #(
    parameter int unsigned MaxEntries = DefMaxEntries,
    parameter int unsigned AddrBits   = DefAddrBits,
    localparam int unsigned IdxBits   = $clog2(MaxEntries),
    localparam int unsigned RowBits   = 2 * AddrBits + 13
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [IdxBits-1:0] i_rd_idx,
    output logic [RowBits-1:0] o_rd_row,
    input  logic               i_wr_en,
    input  logic [IdxBits-1:0] i_wr_idx,
    input  logic [RowBits-1:0] i_wr_row
);
    logic [RowBits-1:0] r_mem [MaxEntries];
    logic [RowBits-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_row = r_rd;
endmodule

// ===== sv/sfa_ctrl.sv =====
// sequencer: scan, select, shift insert and release over the table memory
module sfa_ctrl import sfa_pkg::*; #(
    parameter int unsigned MaxEntries = DefMaxEntries,
    parameter int unsigned AddrBits   = DefAddrBits,
    localparam int unsigned IdxBits   = $clog2(MaxEntries),
    localparam int unsigned CntBits   = $clog2(MaxEntries + 1),
    localparam int unsigned RowBits   = 2 * AddrBits + 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_policy,
    input  logic               i_init,
    input  logic [15:0]        i_init_size,
    sfa_req_if.sink            req,
    sfa_rsp_if.source          rsp,
    output logic               o_rd_en,
    output logic [IdxBits-1:0] o_rd_idx,
    input  logic [RowBits-1:0] i_rd_row,
    output logic               o_wr_en,
    output logic [IdxBits-1:0] o_wr_idx,
    output logic [RowBits-1:0] o_wr_row,
    output logic               o_busy
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StScan  = 3'd1;
    localparam logic [2:0] StShift = 3'd2;
    localparam logic [2:0] StPlace = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;
    localparam logic [2:0] StInit  = 3'd5;

    // row layout: {free, owner[11:0], base, size}
    logic [2:0]          r_st;
    t_request            r_req;
    logic [CntBits-1:0]  r_count;
    logic [AddrBits-1:0] r_free;
    logic [CntBits-1:0]  r_ptr;
    logic                r_rvalid;
    logic [IdxBits-1:0]  r_ridx;
    logic                r_found;
    logic [IdxBits-1:0]  r_pick;
    logic [RowBits-1:0]  r_prow;
    logic                r_done;
    t_result             r_res;
    logic                r_ovalid;
    logic [1:0]          r_ipend;
    logic [15:0]         r_isize;

    logic                rfree;
    logic [11:0]         rown;
    logic [AddrBits-1:0] rbase, rsize, pbase, psize, need;
    logic [11:0]         own;
    logic                fits, better;

    assign {rfree, rown, rbase, rsize} = i_rd_row;
    assign pbase = r_prow[2*AddrBits-1:AddrBits];
    assign psize = r_prow[AddrBits-1:0];
    assign need  = AddrBits'(r_req.request_size);
    assign own   = {r_req.process_id, r_req.segment_id};
    assign fits  = rfree && (rsize >= need);

    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (i_policy == PolicyBest) begin
            better = rsize <= psize;
        end else if (i_policy == PolicyWorst) begin
            better = rsize > psize;
        end else begin
            better = 1'b0;
        end
    end

    assign req.ready = (r_st == StIdle) && !r_ovalid && !i_init && (r_ipend == 2'd0);
    assign rsp.valid = r_ovalid;
    assign rsp.data  = r_res;
    assign o_busy    = r_st != StIdle;

    // read address: scan index, or the row to move during shift
    always_comb begin
        o_rd_en  = 1'b0;
        o_rd_idx = r_ptr[IdxBits-1:0];
        o_wr_en  = 1'b0;
        o_wr_idx = r_pick;
        o_wr_row = '0;
        if (r_st == StScan && r_ptr < r_count && !r_done) begin
            o_rd_en = 1'b1;
        end
        if (r_st == StShift) begin
            o_rd_en  = r_ptr > CntBits'(r_pick) + CntBits'(1);
            o_rd_idx = IdxBits'(r_ptr - CntBits'(1));
            if (r_rvalid) begin
                o_wr_en  = 1'b1;
                o_wr_idx = IdxBits'(r_ridx + IdxBits'(1));
                o_wr_row = i_rd_row;
            end
        end
        if (r_st == StPlace) begin
            o_wr_en = 1'b1;
            if (r_req.opcode == OpRelease) begin
                o_wr_row = {1'b1, 12'd0, pbase, psize};
            end else if (!r_done) begin
                o_wr_idx = r_pick;
                o_wr_row = {1'b0, own, pbase, need};
            end else begin
                o_wr_idx = IdxBits'(r_pick + IdxBits'(1));
                o_wr_row = {1'b1, 12'd0, pbase + need, psize - need};
            end
        end
        if (r_st == StInit) begin
            o_wr_en  = 1'b1;
            o_wr_idx = '0;
            o_wr_row = {1'b1, 12'd0, {AddrBits{1'b0}}, AddrBits'(r_isize)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= o_rd_idx;
        if (!i_rst_n) begin
            r_st     <= StInit;
            r_ovalid <= 1'b0;
            r_count  <= CntBits'(1);
            r_free   <= AddrBits'(MemSizeReset);
            r_isize  <= MemSizeReset;
            r_ipend  <= 2'd0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= o_rd_en;
            if (rsp.valid && rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_init) begin
                r_isize <= i_init_size;
                r_ipend <= 2'd2;
            end else if (r_ipend != 2'd0) begin
                r_ipend <= r_ipend - 2'd1;
                if (r_ipend == 2'd1) begin
                    r_st <= StInit;
                end
            end
            case (r_st)
                StIdle: begin
                    if (req.valid && req.ready) begin
                        r_req   <= req.data;
                        r_ptr   <= '0;
                        r_found <= 1'b0;
                        r_done  <= 1'b0;
                        if (req.data.opcode == OpCreate
                            && AddrBits'(req.data.request_size) > r_free) begin
                            r_res    <= '{StatNoMem, 16'd0, 16'd0, 16'(r_free)};
                            r_st     <= StOut;
                        end else begin
                            r_st <= StScan;
                        end
                    end
                end
                StScan: begin
                    if (o_rd_en) begin
                        r_ptr <= r_ptr + CntBits'(1);
                    end
                    if (r_rvalid) begin
                        if (r_req.opcode == OpRelease) begin
                            if (!rfree && rown == own && !r_found) begin
                                r_found <= 1'b1;
                                r_done  <= 1'b1;
                                r_pick  <= r_ridx;
                                r_prow  <= i_rd_row;
                            end
                        end else if (fits && better && !r_done) begin
                            r_found <= 1'b1;
                            r_pick  <= r_ridx;
                            r_prow  <= i_rd_row;
                            if (i_policy != PolicyBest && i_policy != PolicyWorst) begin
                                r_done <= 1'b1;
                            end
                        end
                    end
                    if (!o_rd_en && !r_rvalid) begin
                        r_done <= 1'b0;
                        if (r_req.opcode == OpRelease) begin
                            if (r_found) begin
                                r_st <= StPlace;
                            end else begin
                                r_res <= '{StatNoMem, 16'd0, 16'd0, 16'(r_free)};
                                r_st  <= StOut;
                            end
                        end else if (!r_found) begin
                            r_res <= '{StatCompact, 16'd0, 16'd0, 16'(r_free)};
                            r_st  <= StOut;
                        end else if (need < psize) begin
                            if (r_count >= CntBits'(MaxEntries)) begin
                                r_res <= '{StatFull, 16'd0, 16'd0, 16'(r_free)};
                                r_st  <= StOut;
                            end else begin
                                r_ptr <= r_count;
                                r_st  <= StShift;
                            end
                        end else begin
                            r_st <= StPlace;
                        end
                    end
                end
                StShift: begin
                    // move rows up one, top first
                    if (o_rd_en) begin
                        r_ptr <= r_ptr - CntBits'(1);
                    end else if (!r_rvalid) begin
                        r_st <= StPlace;
                    end
                end
                StPlace: begin
                    if (r_req.opcode == OpRelease) begin
                        r_free <= r_free + psize;
                        r_res  <= '{StatOk, 16'(pbase), 16'(pbase + psize),
                                    16'(r_free + psize)};
                        r_st   <= StOut;
                    end else if (!r_done && need < psize) begin
                        r_done <= 1'b1;
                    end else begin
                        if (need < psize) begin
                            r_count <= r_count + CntBits'(1);
                        end
                        r_free <= r_free - need;
                        r_res  <= '{StatOk, 16'(pbase), 16'(pbase + need),
                                    16'(r_free - need)};
                        r_st   <= StOut;
                    end
                end
                StOut: begin
                    r_ovalid <= 1'b1;
                    r_st     <= StIdle;
                end
                StInit: begin
                    r_count <= CntBits'(1);
                    r_free  <= AddrBits'(r_isize);
                    r_st    <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule
